@@ rtl/sfr_pkg.sv @@
`timescale 1ns / 1ps

package sfr_pkg;

   // fixed field widths
   localparam int CHAR_W      = 16;
   localparam int LEN_RAW_W   = 4;
   localparam int COUNT_W     = 32;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 6;

   // defaults for the top level parameters
   localparam int MATCH_MAX_DEF   = 8;
   localparam int REPLACE_MAX_DEF = 8;

   // register map, one 64-bit register every 8 bytes
   typedef enum logic [2:0] {
      REG_MATCH_LENGTH       = 3'd0,
      REG_MATCH_CHARS_LOW    = 3'd1,
      REG_MATCH_CHARS_HIGH   = 3'd2,
      REG_REPLACE_LENGTH     = 3'd3,
      REG_REPLACE_CHARS_LOW  = 3'd4,
      REG_REPLACE_CHARS_HIGH = 3'd5,
      REG_REPLACE_LIMIT      = 3'd6,
      REG_LIMIT_OFF          = 3'd7
   } csr_index_type;

   // replacement limit settings
   typedef struct packed {
      logic               limit_off;
      logic [COUNT_W-1:0] replace_limit;
   } limit_cfg_type;

   // write strobe for match_length with the raw value being written
   typedef struct packed {
      logic                 wr;
      logic [LEN_RAW_W-1:0] value;
   } len_write_type;

   // clamp a raw 4-bit length into [lo, hi]
   function automatic int clamp_len(input logic [LEN_RAW_W-1:0] raw,
                                    input int lo, input int hi);
      int v;
      v = int'(raw);
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
   endfunction

endpackage

@@ rtl/stream_find_replace_unit.sv @@
`timescale 1ns / 1ps
// Path: an accepted character's job is registered into the job queue, and its
// first result beat is then registered onto the result ports by the back end.
// Throughput: one character per cycle while each yields at most one beat and
// results are popped; a character that yields more beats (replacement or
// end-of-text flush) holds the back end until all its beats are out, buffered by a 2-entry job queue.
// Reset: synchronous, active high; registers take their defaults, window empty.
module stream_find_replace_unit #(
   parameter int MATCH_MAX   = sfr_pkg::MATCH_MAX_DEF,
   parameter int REPLACE_MAX = sfr_pkg::REPLACE_MAX_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              push,
   output logic                              full,
   input  logic [sfr_pkg::CHAR_W-1:0]        req_text_char,
   input  logic                              req_text_last,
   // result channel
   output logic                              empty,
   input  logic                              pop,
   output logic [sfr_pkg::CHAR_W-1:0]        rsp_out_char,
   output logic                              rsp_char_valid,
   output logic                              rsp_text_end,
   // configuration port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [sfr_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [sfr_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   localparam int NMAX   = (MATCH_MAX > REPLACE_MAX) ? MATCH_MAX : REPLACE_MAX;
   localparam int CNT_W  = $clog2(NMAX + 1);
   localparam int JOB_W  = NMAX * sfr_pkg::CHAR_W + CNT_W + 1;

   // configuration registers
   logic [sfr_pkg::LEN_RAW_W-1:0]  match_length_ff;
   logic [sfr_pkg::CSR_DATA_W-1:0] match_lo_ff, match_hi_ff;
   logic [sfr_pkg::LEN_RAW_W-1:0]  replace_length_ff;
   logic [sfr_pkg::CSR_DATA_W-1:0] replace_lo_ff, replace_hi_ff;
   logic [sfr_pkg::COUNT_W-1:0]    replace_limit_ff;
   logic                           limit_off_ff;

   sfr_pkg::csr_index_type csr_index;
   logic                   csr_wr;
   sfr_pkg::limit_cfg_type limit_cfg;
   sfr_pkg::len_write_type len_write;

   logic [MATCH_MAX-1:0][sfr_pkg::CHAR_W-1:0]   pattern;
   logic [REPLACE_MAX-1:0][sfr_pkg::CHAR_W-1:0] replacement;

   // front to queue to back
   logic                                 job_push, job_last, job_valid, job_take;
   logic [NMAX-1:0][sfr_pkg::CHAR_W-1:0] job_chars, head_chars;
   logic [CNT_W-1:0]                     job_count, head_count;
   logic                                 head_last;
   logic [JOB_W-1:0]                     head_bits;

   assign pready    = 1'b1;
   assign csr_index = sfr_pkg::csr_index_type'(paddr[5:3]);
   assign csr_wr    = psel && penable && pwrite && pready;

   assign limit_cfg.limit_off     = limit_off_ff;
   assign limit_cfg.replace_limit = replace_limit_ff;
   assign len_write.wr    = csr_wr && (csr_index == sfr_pkg::REG_MATCH_LENGTH);
   assign len_write.value = pwdata[3:0];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         match_length_ff   <= sfr_pkg::LEN_RAW_W'(1);
         match_lo_ff       <= '0;
         match_hi_ff       <= '0;
         replace_length_ff <= '0;
         replace_lo_ff     <= '0;
         replace_hi_ff     <= '0;
         replace_limit_ff  <= '0;
         limit_off_ff      <= 1'b1;
      end else if (csr_wr) begin
         unique case (csr_index)
            sfr_pkg::REG_MATCH_LENGTH:       match_length_ff   <= pwdata[3:0];
            sfr_pkg::REG_MATCH_CHARS_LOW:    match_lo_ff       <= pwdata;
            sfr_pkg::REG_MATCH_CHARS_HIGH:   match_hi_ff       <= pwdata;
            sfr_pkg::REG_REPLACE_LENGTH:     replace_length_ff <= pwdata[3:0];
            sfr_pkg::REG_REPLACE_CHARS_LOW:  replace_lo_ff     <= pwdata;
            sfr_pkg::REG_REPLACE_CHARS_HIGH: replace_hi_ff     <= pwdata;
            sfr_pkg::REG_REPLACE_LIMIT:      replace_limit_ff  <= pwdata[31:0];
            sfr_pkg::REG_LIMIT_OFF:          limit_off_ff      <= pwdata[0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      prdata = '0;
      unique case (csr_index)
         sfr_pkg::REG_MATCH_LENGTH:       prdata[3:0]  = match_length_ff;
         sfr_pkg::REG_MATCH_CHARS_LOW:    prdata       = match_lo_ff;
         sfr_pkg::REG_MATCH_CHARS_HIGH:   prdata       = match_hi_ff;
         sfr_pkg::REG_REPLACE_LENGTH:     prdata[3:0]  = replace_length_ff;
         sfr_pkg::REG_REPLACE_CHARS_LOW:  prdata       = replace_lo_ff;
         sfr_pkg::REG_REPLACE_CHARS_HIGH: prdata       = replace_hi_ff;
         sfr_pkg::REG_REPLACE_LIMIT:      prdata[31:0] = replace_limit_ff;
         sfr_pkg::REG_LIMIT_OFF:          prdata[0]    = limit_off_ff;
         default: ;
      endcase
   end

   // unpack pattern and replacement; characters past the eighth read as zero
   always_comb begin
      for (int i = 0; i < MATCH_MAX; i++) begin
         if (i < 4)      pattern[i] = match_lo_ff[16*(i%4) +: 16];
         else if (i < 8) pattern[i] = match_hi_ff[16*(i%4) +: 16];
         else            pattern[i] = '0;
      end
      for (int i = 0; i < REPLACE_MAX; i++) begin
         if (i < 4)      replacement[i] = replace_lo_ff[16*(i%4) +: 16];
         else if (i < 8) replacement[i] = replace_hi_ff[16*(i%4) +: 16];
         else            replacement[i] = '0;
      end
   end

   sfr_front #(
      .MATCH_MAX   (MATCH_MAX),
      .REPLACE_MAX (REPLACE_MAX)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .queue_full      (full),
      .req_text_char   (req_text_char),
      .req_text_last   (req_text_last),
      .match_len_raw   (match_length_ff),
      .replace_len_raw (replace_length_ff),
      .pattern         (pattern),
      .replacement     (replacement),
      .limit_cfg       (limit_cfg),
      .len_write       (len_write),
      .job_push        (job_push),
      .job_chars       (job_chars),
      .job_count       (job_count),
      .job_last        (job_last)
   );

   sfr_job_fifo #(
      .DATA_BITS (JOB_W)
   ) u_job_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (job_push),
      .wr_data  ({job_last, job_count, job_chars}),
      .full     (full),
      .rd_valid (job_valid),
      .rd_data  (head_bits),
      .rd_take  (job_take)
   );

   assign {head_last, head_count, head_chars} = head_bits;

   sfr_back #(
      .JOB_CHARS (NMAX)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (job_valid),
      .job_chars      (head_chars),
      .job_count      (head_count),
      .job_last       (head_last),
      .job_take       (job_take),
      .empty          (empty),
      .pop            (pop),
      .rsp_out_char   (rsp_out_char),
      .rsp_char_valid (rsp_char_valid),
      .rsp_text_end   (rsp_text_end)
   );

   // a bare end marker is the only beat without a character
   a_bare_marker_ends: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_char_valid) |-> (rsp_text_end && (rsp_out_char == '0)))
      else $error("beat without character is not a clean end marker");

   // the back end only retires a job that the queue holds
   a_take_needs_job: assert property (@(posedge clock) disable iff (reset)
      job_take |-> job_valid)
      else $error("job retired from an empty queue");

   // a full job queue holds work and turns the front away
   a_full_blocks_push: assert property (@(posedge clock) disable iff (reset)
      full |-> (job_valid && !job_push))
      else $error("push taken while job queue is full");

endmodule

@@ rtl/sfr_front.sv @@
`timescale 1ns / 1ps

module sfr_front #(
   parameter int MATCH_MAX   = sfr_pkg::MATCH_MAX_DEF,
   parameter int REPLACE_MAX = sfr_pkg::REPLACE_MAX_DEF,
   localparam int NMAX   = (MATCH_MAX > REPLACE_MAX) ? MATCH_MAX : REPLACE_MAX,
   localparam int FILL_W = $clog2(MATCH_MAX + 1),
   localparam int CNT_W  = $clog2(NMAX + 1)
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // input channel
   input  logic                                    push,
   input  logic                                    queue_full,
   input  logic [sfr_pkg::CHAR_W-1:0]              req_text_char,
   input  logic                                    req_text_last,
   // configuration
   input  logic [sfr_pkg::LEN_RAW_W-1:0]           match_len_raw,
   input  logic [sfr_pkg::LEN_RAW_W-1:0]           replace_len_raw,
   input  logic [MATCH_MAX-1:0][sfr_pkg::CHAR_W-1:0]   pattern,
   input  logic [REPLACE_MAX-1:0][sfr_pkg::CHAR_W-1:0] replacement,
   input  sfr_pkg::limit_cfg_type                  limit_cfg,
   input  sfr_pkg::len_write_type                  len_write,
   // job out to the queue
   output logic                                    job_push,
   output logic [NMAX-1:0][sfr_pkg::CHAR_W-1:0]    job_chars,
   output logic [CNT_W-1:0]                        job_count,
   output logic                                    job_last
);

   logic [MATCH_MAX-1:0][sfr_pkg::CHAR_W-1:0] win_ff, win_in, win_new;
   logic [FILL_W-1:0]                         fill_ff, fill_in;
   logic [sfr_pkg::COUNT_W-1:0]               done_ff, done_in;

   logic [FILL_W-1:0] len_eff, len_wr_eff, fill_base, fill_inc;
   logic [CNT_W-1:0]  rep_len_eff;
   logic              win_full, same, allowed, hit;

   assign len_eff     = FILL_W'(sfr_pkg::clamp_len(match_len_raw, 1, MATCH_MAX));
   assign len_wr_eff  = FILL_W'(sfr_pkg::clamp_len(len_write.value, 1, MATCH_MAX));
   assign rep_len_eff = CNT_W'(sfr_pkg::clamp_len(replace_len_raw, 0, REPLACE_MAX));
   assign job_push    = push && !queue_full;
   assign job_last    = req_text_last;

   // window update, pattern compare and job build for one character
   always_comb begin
      fill_base = (fill_ff >= len_eff) ? '0 : fill_ff;
      win_new   = win_ff;
      for (int i = 0; i < MATCH_MAX; i++) begin
         if (FILL_W'(i) == fill_base) win_new[i] = req_text_char;
      end
      fill_inc = fill_base + 1'b1;
      win_full = (fill_inc == len_eff);

      same = 1'b1;
      for (int i = 0; i < MATCH_MAX; i++) begin
         if ((FILL_W'(i) < len_eff) && (win_new[i] != pattern[i])) same = 1'b0;
      end
      allowed = limit_cfg.limit_off || (done_ff < limit_cfg.replace_limit);
      hit     = win_full && same && allowed;

      // result characters: replacement on a hit, else the window itself
      job_chars = '0;
      if (hit) begin
         for (int i = 0; i < REPLACE_MAX; i++) job_chars[i] = replacement[i];
      end else begin
         for (int i = 0; i < MATCH_MAX; i++) job_chars[i] = win_new[i];
      end

      if (hit)
         job_count = rep_len_eff;
      else if (win_full)
         job_count = req_text_last ? CNT_W'(len_eff) : CNT_W'(1);
      else
         job_count = req_text_last ? CNT_W'(fill_inc) : '0;

      // next window state
      win_in  = win_ff;
      fill_in = fill_ff;
      done_in = done_ff;
      if (job_push) begin
         win_in = win_new;
         if (win_full && !hit) begin
            for (int i = 0; i < MATCH_MAX - 1; i++) win_in[i] = win_new[i + 1];
         end
         if (hit)
            fill_in = '0;
         else if (win_full)
            fill_in = len_eff - 1'b1;
         else
            fill_in = fill_inc;
         if (hit && (done_ff != '1)) done_in = done_ff + 1'b1;
         if (req_text_last) begin
            fill_in = '0;
            done_in = '0;
         end
      end else if (len_write.wr && (fill_ff >= len_wr_eff)) begin
         // shorter pattern drops held characters
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         done_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

@@ rtl/sfr_job_fifo.sv @@
`timescale 1ns / 1ps

module sfr_job_fifo #(
   parameter int DATA_BITS = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [DATA_BITS-1:0] wr_data,
   output logic                 full,
   output logic                 rd_valid,
   output logic [DATA_BITS-1:0] rd_data,
   input  logic                 rd_take
);

   logic [DATA_BITS-1:0] mem_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;
   logic                 do_wr, do_rd;

   assign full     = (count_ff == 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_take && rd_valid;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = do_wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) mem_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

@@ rtl/sfr_back.sv @@
`timescale 1ns / 1ps

module sfr_back #(
   parameter int JOB_CHARS = sfr_pkg::MATCH_MAX_DEF,
   localparam int CNT_W = $clog2(JOB_CHARS + 1)
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // job from the queue
   input  logic                                     job_valid,
   input  logic [JOB_CHARS-1:0][sfr_pkg::CHAR_W-1:0] job_chars,
   input  logic [CNT_W-1:0]                         job_count,
   input  logic                                     job_last,
   output logic                                     job_take,
   // result channel
   output logic                                     empty,
   input  logic                                     pop,
   output logic [sfr_pkg::CHAR_W-1:0]               rsp_out_char,
   output logic                                     rsp_char_valid,
   output logic                                     rsp_text_end
);

   logic [CNT_W-1:0]          pos_ff, pos_in;
   logic                      valid_ff, valid_in;
   logic [sfr_pkg::CHAR_W-1:0] char_ff, char_in;
   logic                      cvalid_ff, cvalid_in;
   logic                      end_ff, end_in;

   logic                      slot_free, no_chars, drop_job, final_beat, emit;
   logic [sfr_pkg::CHAR_W-1:0] sel_char;

   assign empty          = !valid_ff;
   assign rsp_out_char   = char_ff;
   assign rsp_char_valid = cvalid_ff;
   assign rsp_text_end   = end_ff;

   // walk through the job one beat at a time
   always_comb begin
      slot_free  = !valid_ff || pop;
      no_chars   = (job_count == '0);
      drop_job   = no_chars && !job_last;
      final_beat = no_chars || (pos_ff == job_count - 1'b1);
      emit       = job_valid && slot_free && !drop_job;
      job_take   = job_valid && (drop_job || (emit && final_beat));

      sel_char = '0;
      for (int i = 0; i < JOB_CHARS; i++) begin
         if (CNT_W'(i) == pos_ff) sel_char = job_chars[i];
      end

      pos_in    = pos_ff;
      valid_in  = valid_ff;
      char_in   = char_ff;
      cvalid_in = cvalid_ff;
      end_in    = end_ff;
      if (emit) begin
         valid_in  = 1'b1;
         char_in   = no_chars ? '0 : sel_char;
         cvalid_in = !no_chars;
         end_in    = job_last && final_beat;
         pos_in    = final_beat ? '0 : pos_ff + 1'b1;
      end else if (pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff   <= char_in;
      cvalid_ff <= cvalid_in;
      end_ff    <= end_in;
   end

endmodule
